/* src/nos_pkg.sv */
// Package for the neighbour overlap similarity block: constants, codes and state type.
package nos_pkg;

	localparam int NODES_DEF = 64;
	localparam int CHUNK     = 16;
	localparam int QW        = 16;
	localparam int IDXW      = 6;
	localparam int ROWW      = 64;
	localparam int CNTW      = 7;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AND,
		ST_CNT,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} st_t;

endpackage

/* src/neighbour_overlap_similarity.sv */
// Neighbour overlap similarity: row store, bit counter, multiplier and serial divider.
//
// channel | direction | handshake             | word
// in      | sink      | in_valid / in_ready   | action, row_index, row_bits, col_index
// out     | source    | out_valid / out_ready | similarity_q16, common_count, index_error
// cfg     | sink      | cfg_valid / cfg_ready | cfg_data (node_count)
//
// One word at a time; in_ready is high only while the sequencer is idle.
// Load: ST_CNT counts the stored row, 16 row bits per cycle; an ignored load skips the count.
// Query: ST_AND, ST_CNT, ST_MUL, ST_DIV, then ST_FIN; the 16-step restoring divider dominates.
// Out-of-range or equal-index queries go straight to ST_FIN.
// Results wait in an output register; a stall there holds only the final step.
// Reset clears control and sets node_count to NODES; the row store is not cleared.
module neighbour_overlap_similarity #(
	parameter int NODES = nos_pkg::NODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [nos_pkg::IDXW-1:0]   row_index,
	input  logic [nos_pkg::ROWW-1:0]   row_bits,
	input  logic [nos_pkg::IDXW-1:0]   col_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [nos_pkg::QW-1:0]     similarity_q16,
	output logic [nos_pkg::CNTW-1:0]   common_count,
	output logic                       index_error,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [nos_pkg::CNTW-1:0]   cfg_data
);
	import nos_pkg::*;

	localparam int AW   = $clog2(NODES);
	localparam int NCH  = (NODES + CHUNK - 1) / CHUNK;
	localparam int PW   = NCH * CHUNK;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int DVW  = $clog2(QW);
	localparam logic [CNTW-1:0] NODES_C = CNTW'(NODES);

	st_t state_q, state_d;

	logic [CNTW-1:0]  node_count_q;
	logic [CNTW-1:0]  n_act;
	logic             in_fire;
	logic             ld_ok;
	logic             q_oob;
	logic             q_same;
	logic [NODES-1:0] col_mask;
	logic [NODES-1:0] own_bit;
	logic [NODES-1:0] row_in;

	logic [NODES-1:0] rows_mem [NODES];
	logic [CNTW-1:0]  cnt_mem  [NODES];

	logic [NODES-1:0] rd_a_s1, rd_b_s1;
	logic [CNTW-1:0]  cnt_a_s1, cnt_b_s1;

	logic             is_load_q;
	logic [AW-1:0]    addr_q;
	logic [PW-1:0]    shreg_q;
	logic [CHW-1:0]   chunk_q;
	logic [CNTW-1:0]  acc_q;
	logic [4:0]       chunk_pc;
	logic [CNTW-1:0]  acc_nxt;
	logic             chunk_last;

	logic [CNTW-1:0]  ni_q, nj_q, c_q;
	logic [7:0]       fac_i, fac_j;
	logic [13:0]      csq;
	logic [QW-1:0]    den_q;
	logic [QW-1:0]    rem_q;
	logic [QW:0]      rem_sh;
	logic             rem_ge;
	logic [QW-1:0]    quo_q;
	logic [DVW-1:0]   div_q;
	logic             div_last;
	logic             res_err_q;

	logic             out_valid_q;
	logic [QW-1:0]    sim_out_q;
	logic [CNTW-1:0]  cnt_out_q;
	logic             err_out_q;
	logic             out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign similarity_q16 = sim_out_q;
	assign common_count   = cnt_out_q;
	assign index_error    = err_out_q;

	assign n_act  = (node_count_q > NODES_C) ? NODES_C : node_count_q;
	assign ld_ok  = ({1'b0, row_index} < n_act);
	assign q_oob  = !ld_ok || !({1'b0, col_index} < n_act);
	assign q_same = (row_index == col_index);

	always_comb begin
		for (int k = 0; k < NODES; k++) begin
			col_mask[k] = (CNTW'(k) < n_act);
			own_bit[k]  = (row_index == IDXW'(k));
		end
		row_in = (row_bits[NODES-1:0] & col_mask) | own_bit;
	end

	always_comb begin
		chunk_pc = '0;
		for (int i = 0; i < CHUNK; i++) begin
			chunk_pc = chunk_pc + 5'(shreg_q[i]);
		end
		acc_nxt = acc_q + CNTW'(chunk_pc);
	end

	assign chunk_last = (chunk_q == CHW'(NCH - 1));
	assign div_last   = (div_q == DVW'(QW - 1));

	assign fac_i  = 8'(ni_q) + 8'(c_q) + 8'd1;
	assign fac_j  = 8'(nj_q) + 8'(c_q) + 8'd1;
	assign csq    = 14'(c_q) * 14'(c_q);
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (action == ACT_LOAD) begin
						state_d = ld_ok ? ST_CNT : ST_IDLE;
					end else begin
						state_d = (q_oob || q_same) ? ST_FIN : ST_AND;
					end
				end
			end
			ST_AND: state_d = ST_CNT;
			ST_CNT: begin
				if (chunk_last) begin
					state_d = is_load_q ? ST_IDLE : ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODES_C;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// row and count store
	always_ff @(posedge clk) begin
		if (in_fire && action == ACT_LOAD && ld_ok) begin
			rows_mem[row_index[AW-1:0]] <= row_in;
		end
		if (state_q == ST_CNT && chunk_last && is_load_q) begin
			cnt_mem[addr_q] <= acc_nxt;
		end
		if (in_fire && action == ACT_QUERY) begin
			rd_a_s1  <= rows_mem[row_index[AW-1:0]];
			rd_b_s1  <= rows_mem[col_index[AW-1:0]];
			cnt_a_s1 <= cnt_mem[row_index[AW-1:0]];
			cnt_b_s1 <= cnt_mem[col_index[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					is_load_q <= (action == ACT_LOAD);
					addr_q    <= row_index[AW-1:0];
					shreg_q   <= PW'(row_in);
					chunk_q   <= '0;
					acc_q     <= '0;
					c_q       <= '0;
					quo_q     <= '0;
					res_err_q <= q_oob;
				end
			end
			ST_AND: begin
				shreg_q <= PW'(rd_a_s1 & rd_b_s1);
				ni_q    <= cnt_a_s1;
				nj_q    <= cnt_b_s1;
			end
			ST_CNT: begin
				shreg_q <= shreg_q >> CHUNK;
				chunk_q <= chunk_q + CHW'(1);
				acc_q   <= acc_nxt;
				if (chunk_last) begin
					c_q <= acc_nxt;
				end
			end
			ST_MUL: begin
				den_q <= QW'(fac_i) * QW'(fac_j);
				rem_q <= {csq, 2'b00};
				div_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_ge ? QW'(rem_sh - {1'b0, den_q}) : rem_sh[QW-1:0];
				quo_q <= {quo_q[QW-2:0], rem_ge};
				div_q <= div_q + DVW'(1);
			end
			ST_FIN: begin
				if (out_free) begin
					sim_out_q <= quo_q;
					cnt_out_q <= c_q;
					err_out_q <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> similarity_q16 == '0 && common_count == '0)
		else $error("error word carries nonzero fields");

	a_sim_needs_common: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && similarity_q16 != '0 |-> common_count != '0 && !index_error)
		else $error("similarity without common neighbours");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> common_count <= NODES_C)
		else $error("common count above node total");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside final step");

endmodule
